FILE: rtl/bcd_pkg.sv
// shared types, constants and register codes of the band energy cutoff detector
package bcd_pkg;

  localparam int BIN_W      = 13;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 48;
  localparam int RATIO_W    = 16;
  localparam int SQ_W       = 2 * SAMPLE_W - 1;
  localparam int ENERGY_W   = 2 * SAMPLE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int PP_SPLIT   = 24;

  localparam logic [BIN_W-1:0] COUNT_MAX  = 13'd8191;
  localparam logic [BIN_W-1:0] HALF_LIMIT = 13'd4096;
  localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_BIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_START     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_FLOOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_THRESH  = 3'd4;

  typedef enum logic [1:0] {
    VERD_CUTOFF    = 2'd0,
    VERD_NO_CUTOFF = 2'd1,
    VERD_BAD_SETUP = 2'd2,
    VERD_SILENT    = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    BAND_NONE = 2'd0,
    BAND_MID  = 2'd1,
    BAND_HIGH = 2'd2
  } band_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] bin_real;
    logic signed [SAMPLE_W-1:0] bin_imag;
    logic                       frame_end;
  } in_item_t;

  typedef struct packed {
    logic             cutoff_found;
    logic [1:0]       verdict;
    logic [SUM_W-1:0] high_band_energy;
    logic [SUM_W-1:0] mid_band_energy;
  } out_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]   half_size;
    logic [BIN_W-1:0]   cutoff_bin;
    logic [BIN_W-1:0]   mid_start_bin;
    logic [SUM_W-1:0]   silence_floor;
    logic [RATIO_W-1:0] ratio_thresh;
  } cfg_t;

  // one classified bin on its way from the front to the back
  typedef struct packed {
    band_t                      band;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       last;
  } bin_entry_t;

endpackage

FILE: rtl/bcd_front.sv
// front end: numbers incoming bins and sorts them into bands
module bcd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  bcd_pkg::in_item_t in_data,
  input  bcd_pkg::cfg_t     cfg,
  output logic              push,
  output bcd_pkg::bin_entry_t entry
);
  import bcd_pkg::*;

  logic [BIN_W-1:0] bin_cnt_r, bin_cnt_nxt;
  logic [BIN_W-1:0] half;

  assign push = in_valid && !in_stall;
  assign half = (cfg.half_size > HALF_LIMIT) ? HALF_LIMIT : cfg.half_size;

  always_comb begin
    entry.re   = in_data.bin_real;
    entry.im   = in_data.bin_imag;
    entry.last = in_data.frame_end;
    if (bin_cnt_r >= half) begin
      entry.band = BAND_NONE;
    end else if (bin_cnt_r >= cfg.cutoff_bin) begin
      entry.band = BAND_HIGH;
    end else if (bin_cnt_r >= cfg.mid_start_bin) begin
      entry.band = BAND_MID;
    end else begin
      entry.band = BAND_NONE;
    end
  end

  always_comb begin
    bin_cnt_nxt = bin_cnt_r;
    if (push) begin
      if (in_data.frame_end) begin
        bin_cnt_nxt = '0;
      end else if (bin_cnt_r < COUNT_MAX) begin
        bin_cnt_nxt = bin_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '0;
    end else begin
      bin_cnt_r <= bin_cnt_nxt;
    end
  end

endmodule

FILE: rtl/bcd_fifo.sv
// short queue of classified bins between front and back
module bcd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bcd_pkg::bin_entry_t push_data,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output bcd_pkg::bin_entry_t pop_data
);
  import bcd_pkg::*;

  bin_entry_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     count_r, count_nxt;
  logic                 do_pop;

  assign full      = (count_r == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/bcd_back.sv
// back end: squares, band accumulation, ratio test and result register
module bcd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bcd_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  bcd_pkg::bin_entry_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bcd_pkg::out_item_t  out_data
);
  import bcd_pkg::*;

  localparam int PP_LO_W = RATIO_W + PP_SPLIT;
  localparam int PP_HI_W = RATIO_W + SUM_W - PP_SPLIT;
  localparam int PROD_W  = RATIO_W + SUM_W;

  logic en;

  // square stage
  logic            s1_valid_r;
  band_t           s1_band_r;
  logic            s1_last_r;
  logic [SQ_W-1:0] s1_sq_re_r, s1_sq_im_r;
  logic signed [2*SAMPLE_W-1:0] sq_re, sq_im;

  // accumulators
  logic [SUM_W-1:0]    high_acc_r, high_acc_nxt;
  logic [SUM_W-1:0]    mid_acc_r, mid_acc_nxt;
  logic [ENERGY_W-1:0] energy;
  logic [SUM_W:0]      high_sum, mid_sum;
  logic [SUM_W-1:0]    high_fin, mid_fin;

  // frame total stage
  logic             v1_valid_r;
  logic [SUM_W-1:0] v1_high_r, v1_mid_r;

  // partial product stage
  logic               v2_valid_r;
  logic [SUM_W-1:0]   v2_high_r, v2_mid_r;
  logic               v2_bad_r, v2_silent_r;
  logic [PP_LO_W-1:0] v2_pp_lo_r;
  logic [PP_HI_W-1:0] v2_pp_hi_r;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] high_shift;
  verdict_t          verd;

  logic      out_valid_r;
  out_item_t out_data_r;

  // the whole back end holds while a finished result waits
  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en;

  assign sq_re = q_data.re * q_data.re;
  assign sq_im = q_data.im * q_data.im;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_band_r  <= q_data.band;
      s1_last_r  <= q_data.last;
      s1_sq_re_r <= sq_re[SQ_W-1:0];
      s1_sq_im_r <= sq_im[SQ_W-1:0];
    end
  end

  assign energy   = ENERGY_W'(s1_sq_re_r) + ENERGY_W'(s1_sq_im_r);
  assign high_sum = {1'b0, high_acc_r} + (SUM_W+1)'(energy);
  assign mid_sum  = {1'b0, mid_acc_r} + (SUM_W+1)'(energy);

  always_comb begin
    high_fin = high_acc_r;
    mid_fin  = mid_acc_r;
    case (s1_band_r)
      BAND_HIGH: high_fin = high_sum[SUM_W] ? SUM_MAX : high_sum[SUM_W-1:0];
      BAND_MID:  mid_fin  = mid_sum[SUM_W] ? SUM_MAX : mid_sum[SUM_W-1:0];
      default: ;
    endcase
    high_acc_nxt = high_acc_r;
    mid_acc_nxt  = mid_acc_r;
    if (en && s1_valid_r) begin
      high_acc_nxt = s1_last_r ? '0 : high_fin;
      mid_acc_nxt  = s1_last_r ? '0 : mid_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_high_r <= high_fin;
      v1_mid_r  <= mid_fin;
      v2_high_r <= v1_high_r;
      v2_mid_r  <= v1_mid_r;
      v2_bad_r  <= (cfg.cutoff_bin >= ((cfg.half_size > HALF_LIMIT) ? HALF_LIMIT
                                                                    : cfg.half_size))
                   || (cfg.mid_start_bin >= cfg.cutoff_bin);
      v2_silent_r <= (v1_mid_r <= cfg.silence_floor);
      v2_pp_lo_r  <= cfg.ratio_thresh * v1_mid_r[PP_SPLIT-1:0];
      v2_pp_hi_r  <= cfg.ratio_thresh * v1_mid_r[SUM_W-1:PP_SPLIT];
    end
  end

  // high * 65536 < ratio_thresh * mid
  assign prod       = {v2_pp_hi_r, {PP_SPLIT{1'b0}}} + PROD_W'(v2_pp_lo_r);
  assign high_shift = {v2_high_r, {RATIO_W{1'b0}}};

  always_comb begin
    if (v2_bad_r) begin
      verd = VERD_BAD_SETUP;
    end else if (v2_silent_r) begin
      verd = VERD_SILENT;
    end else if (high_shift < prod) begin
      verd = VERD_CUTOFF;
    end else begin
      verd = VERD_NO_CUTOFF;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v2_valid_r) begin
      out_data_r.cutoff_found     <= (verd == VERD_CUTOFF);
      out_data_r.verdict          <= verd;
      out_data_r.high_band_energy <= v2_high_r;
      out_data_r.mid_band_energy  <= v2_mid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      v1_valid_r  <= 1'b0;
      v2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      high_acc_r  <= '0;
      mid_acc_r   <= '0;
    end else begin
      high_acc_r <= high_acc_nxt;
      mid_acc_r  <= mid_acc_nxt;
      if (en) begin
        s1_valid_r  <= q_valid;
        v1_valid_r  <= s1_valid_r && s1_last_r;
        v2_valid_r  <= v1_valid_r;
        out_valid_r <= v2_valid_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/band_energy_cutoff_detector_unit.sv
// top level of the band energy cutoff detector with its register file
//
// Bins of one frame enter on the in_ channel (in_valid / in_stall), one per
// cycle, in index order; the bin index is counted internally from zero.
// A bin with frame_end set closes the frame and causes exactly one result
// transaction on the out_ channel; every other bin causes none.
// Throughput is one bin per cycle while in_stall is low. After the closing
// bin is taken, a result passes the queue write, squaring, band accumulation,
// ratio partial products, then the output register.
// A four-entry queue parts the front (bin counter and band sort) from the
// back (squares, saturating sums, verdict). While out_stall holds a waiting
// result the back freezes, the queue keeps taking bins, and in_stall rises
// only once the queue is full.
// Registers are written through cfg_valid / cfg_ready / cfg_index /
// cfg_data; cfg_ready is always high and unknown indexes are dropped.
// Reset (rst_n low, synchronous) loads the register defaults and clears the
// bin counter, both band sums, the queue and all pipeline valids.
module band_energy_cutoff_detector_unit (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  bcd_pkg::in_item_t                          in_data,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output bcd_pkg::out_item_t                         out_data,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [bcd_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [bcd_pkg::SUM_W-1:0]                  cfg_data
);
  import bcd_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       push;
  bin_entry_t push_entry;
  logic       q_full, q_valid, q_pop;
  bin_entry_t q_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HALF_SIZE:     cfg_nxt.half_size     = cfg_data[BIN_W-1:0];
        REG_CUTOFF_BIN:    cfg_nxt.cutoff_bin    = cfg_data[BIN_W-1:0];
        REG_MID_START:     cfg_nxt.mid_start_bin = cfg_data[BIN_W-1:0];
        REG_SILENCE_FLOOR: cfg_nxt.silence_floor = cfg_data;
        REG_RATIO_THRESH:  cfg_nxt.ratio_thresh  = cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_size     <= 13'd256;
      cfg_r.cutoff_bin    <= 13'd93;
      cfg_r.mid_start_bin <= 13'd58;
      cfg_r.silence_floor <= '0;
      cfg_r.ratio_thresh  <= 16'd655;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bcd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .push     (push),
    .entry    (push_entry)
  );

  bcd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  bcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: verif/bcd_verdict_checker.sv
// checker for the band energy cutoff detector: predicts each frame verdict and compares results
`timescale 1ns / 1ps

module bcd_verdict_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  bcd_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  bcd_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcd_pkg::SUM_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            outstanding,
  output int                            frames_judged,
  output logic [3:0]                    verdicts_seen
);
  import bcd_pkg::*;

  // shadow copy of the register file
  logic [BIN_W-1:0]   half_reg;
  logic [BIN_W-1:0]   cutoff_reg;
  logic [BIN_W-1:0]   mid_start_reg;
  logic [SUM_W-1:0]   floor_reg;
  logic [RATIO_W-1:0] thresh_reg;

  // frame state
  logic [BIN_W-1:0] bin_idx;
  logic [SUM_W-1:0] high_acc;
  logic [SUM_W-1:0] mid_acc;

  out_item_t frame_verdicts[$];

  function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] acc,
                                               input logic [63:0] e);
    logic [63:0] s;
    s = {16'h0, acc} + e;
    return (s > {16'h0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // folds one bin into the band sums; returns 1 with the verdict when the frame closes
  function automatic bit accumulate_bin(input in_item_t b, output out_item_t res);
    logic [BIN_W-1:0] lim;
    longint           re;
    longint           im;
    logic [63:0]      e;
    logic [63:0]      lhs;
    logic [63:0]      rhs;
    verdict_t         v;
    lim = (half_reg > HALF_LIMIT) ? HALF_LIMIT : half_reg;
    re  = longint'(b.bin_real);
    im  = longint'(b.bin_imag);
    e   = re * re + im * im;
    if (bin_idx < lim) begin
      if (bin_idx >= cutoff_reg) high_acc = add_sat(high_acc, e);
      else if (bin_idx >= mid_start_reg) mid_acc = add_sat(mid_acc, e);
    end
    if (bin_idx < COUNT_MAX) bin_idx = bin_idx + 1'b1;
    res = '0;
    if (!b.frame_end) return 1'b0;
    // high / mid < ratio done as high * 2^16 < ratio * mid
    lhs = {high_acc, 16'h0};
    rhs = {16'h0, mid_acc};
    rhs = rhs * thresh_reg;
    if (cutoff_reg >= lim || mid_start_reg >= cutoff_reg) v = VERD_BAD_SETUP;
    else if (mid_acc <= floor_reg) v = VERD_SILENT;
    else if (lhs < rhs) v = VERD_CUTOFF;
    else v = VERD_NO_CUTOFF;
    res.cutoff_found     = (v == VERD_CUTOFF);
    res.verdict          = v;
    res.high_band_energy = high_acc;
    res.mid_band_energy  = mid_acc;
    bin_idx  = '0;
    high_acc = '0;
    mid_acc  = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t fresh;
    out_item_t want;
    if (!rst_n) begin
      half_reg      = 13'd256;
      cutoff_reg    = 13'd93;
      mid_start_reg = 13'd58;
      floor_reg     = '0;
      thresh_reg    = 16'd655;
      bin_idx       = '0;
      high_acc      = '0;
      mid_acc       = '0;
      frame_verdicts.delete();
      mismatches    <= 0;
      outstanding   <= 0;
      frames_judged <= 0;
      verdicts_seen <= '0;
    end else begin
      // a bin taken at a register write edge still sees the old value
      if (in_valid && !in_stall) begin
        if (accumulate_bin(in_data, fresh))
          frame_verdicts.insert(frame_verdicts.size(), fresh);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HALF_SIZE:     half_reg      = cfg_data[BIN_W-1:0];
          REG_CUTOFF_BIN:    cutoff_reg    = cfg_data[BIN_W-1:0];
          REG_MID_START:     mid_start_reg = cfg_data[BIN_W-1:0];
          REG_SILENCE_FLOOR: floor_reg     = cfg_data;
          REG_RATIO_THRESH:  thresh_reg    = cfg_data[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (frame_verdicts.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result transaction with no frame closed: verdict %0d high %0h mid %0h",
                     $realtime, out_data.verdict, out_data.high_band_energy,
                     out_data.mid_band_energy);
          mismatches <= mismatches + 1;
        end else begin
          want = frame_verdicts.pop_front();
          frames_judged <= frames_judged + 1;
          verdicts_seen[want.verdict] <= 1'b1;
          if (out_data.cutoff_found !== want.cutoff_found ||
              out_data.verdict !== want.verdict ||
              out_data.high_band_energy !== want.high_band_energy ||
              out_data.mid_band_energy !== want.mid_band_energy) begin
            if (mismatches < 10)
              $display("%0t: frame %0d mismatch: found exp %0b got %0b, verdict exp %0d got %0d",
                       $realtime, frames_judged, want.cutoff_found, out_data.cutoff_found,
                       want.verdict, out_data.verdict);
            if (mismatches < 10)
              $display("  high exp %0h got %0h, mid exp %0h got %0h",
                       want.high_band_energy, out_data.high_band_energy,
                       want.mid_band_energy, out_data.mid_band_energy);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= frame_verdicts.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
// testbench top: clock, reset, bin and register stimulus, result back-pressure and verdict
`timescale 1ns / 1ps

module tb_top;
  import bcd_pkg::*;

  localparam int RANDOM_BINS = 1200;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SUM_W-1:0]     cfg_data;

  int         mismatches;
  int         outstanding;
  int         frames_judged;
  logic [3:0] verdicts_seen;

  bit calm;
  int bins_sent;
  int settings_loaded;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  band_energy_cutoff_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bcd_verdict_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .frames_judged (frames_judged),
    .verdicts_seen (verdicts_seen)
  );

  task automatic send_bin(input int re, input int im, input bit last);
    int       gap;
    in_item_t item;
    gap = calm ? 0 : $urandom_range(0, 6);
    item.bin_real  = SAMPLE_W'(re);
    item.bin_imag  = SAMPLE_W'(im);
    item.frame_end = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    bins_sent++;
  endtask

  // random bins, bins from cut upwards scaled by their own shift or zeroed by hquiet
  task automatic send_frame(input int len, input int cut, input int mshift, input int hshift,
                            input bit hquiet);
    int                         i;
    int                         sh;
    logic [31:0]                r;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    for (i = 0; i < len; i++) begin
      r  = $urandom;
      sh = (i >= cut) ? hshift : mshift;
      re = $signed(r[15:0]) >>> sh;
      im = $signed(r[31:16]) >>> sh;
      if (i >= cut && hquiet) begin
        re = '0;
        im = '0;
      end
      if ($urandom_range(0, 31) == 0) begin
        re = 16'sh8000;
        im = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      end
      send_bin(int'(re), int'(im), i == len - 1);
    end
  endtask

  // lets the pipeline empty before the register file is touched
  task automatic wait_idle;
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SUM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // narrow registers may carry rubbish above their width
  function automatic logic [SUM_W-1:0] with_junk(input int v, input int w, input bit junk);
    logic [SUM_W-1:0] mask;
    logic [SUM_W-1:0] fill;
    logic [SUM_W-1:0] val;
    mask = (48'd1 << w) - 1'b1;
    fill = junk ? SUM_W'({$urandom, $urandom}) : '0;
    val  = SUM_W'(v);
    return (fill & ~mask) | (val & mask);
  endfunction

  task automatic load_regs(input int half, input int cut, input int mid,
                           input logic [SUM_W-1:0] emin, input int ratio, input bit junk);
    wait_idle();
    write_reg(REG_HALF_SIZE, with_junk(half, BIN_W, junk));
    write_reg(REG_CUTOFF_BIN, with_junk(cut, BIN_W, junk));
    write_reg(REG_MID_START, with_junk(mid, BIN_W, junk));
    write_reg(REG_SILENCE_FLOOR, emin);
    write_reg(REG_RATIO_THRESH, with_junk(ratio, RATIO_W, junk));
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  initial begin : result_backpressure
    int n;
    int k;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      n = calm ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        // hold off a waiting result, counting only edges where out_valid is high
        out_stall <= 1'b1;
        k = 0;
        while (k < n) begin
          @(posedge clk);
          if (out_valid) k++;
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int               half;
    int               cut;
    int               mid;
    int               ratio;
    int               span;
    int               mode;
    int               rnd_base;
    logic [SUM_W-1:0] emin;
    logic [63:0]      w;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    calm            = 1'b0;
    bins_sent       = 0;
    settings_loaded = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // small bands with hand-picked energies around each threshold
    load_regs(4, 2, 1, 48'd5, 16'hffff, 1'b0);
    // mid energy equal to the silence floor
    send_bin(-32768, -32768, 1'b0);
    send_bin(1, 2, 1'b0);
    send_bin(32767, -32768, 1'b0);
    send_bin(0, 0, 1'b1);
    // high under the ratio, frame closed before half size
    send_bin(0, 0, 1'b0);
    send_bin(2, 2, 1'b0);
    send_bin(2, 1, 1'b1);
    // high exactly at the ratio, last bin past half size
    send_bin(0, 0, 1'b0);
    send_bin(2, 2, 1'b0);
    send_bin(2, 2, 1'b0);
    send_bin(0, 0, 1'b0);
    send_bin(-32768, 32767, 1'b1);
    // one-bin frame
    send_bin(-32768, 32767, 1'b1);
    // cutoff at half size
    load_regs(4, 4, 1, 48'd5, 16'hffff, 1'b0);
    send_bin(3, 4, 1'b0);
    send_bin(5, 5, 1'b0);
    send_bin(7, -7, 1'b1);
    // mid start at cutoff
    load_regs(4, 2, 2, 48'd0, 0, 1'b0);
    send_bin(1, 1, 1'b0);
    send_bin(1, 1, 1'b1);
    // writes to unused indexes must leave the file alone
    wait_idle();
    write_reg(REG_MID_START, 48'd1);
    write_reg(REG_SPARE_FIRST, SUM_MAX);
    write_reg(REG_SPARE_LAST, SUM_MAX);
    cfg_valid <= 1'b0;
    send_bin(1, 0, 1'b0);
    send_bin(1, 0, 1'b0);
    send_bin(0, 0, 1'b1);

    // smallest half size with the widest thresholds
    load_regs(1, 0, 0, SUM_MAX, 16'hffff, 1'b1);
    repeat (2) send_frame($urandom_range(1, 4), 0, 0, 0, 1'b0);

    // an oversized half size acts as the largest bin limit
    load_regs(8191, 4096, 0, 48'h10_0000, 16'hffff, 1'b0);
    send_frame(40, 4096, 2, 0, 1'b0);
    load_regs(5000, 4095, 0, 48'h10_0000, 16'hffff, 1'b0);
    send_frame(40, 4095, 2, 0, 1'b0);

    rnd_base = bins_sent;
    while (bins_sent - rnd_base < RANDOM_BINS) begin
      calm = ($urandom_range(0, 4) == 0);
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        half = $urandom_range(1, 64);
        if ($urandom_range(0, 1)) begin
          cut = $urandom_range(half, 8191);
          mid = $urandom_range(0, 8191);
        end else begin
          cut = $urandom_range(0, half - 1);
          mid = $urandom_range(cut, 8191);
        end
        span = half + 8;
      end else if (mode == 1) begin
        half = $urandom_range(4096, 8191);
        cut  = $urandom_range(1, 40);
        mid  = $urandom_range(0, cut - 1);
        span = cut + 24;
      end else begin
        half = $urandom_range(2, 48);
        cut  = $urandom_range(1, half - 1);
        mid  = $urandom_range(0, cut - 1);
        span = half + 8;
      end
      case ($urandom_range(0, 3))
        0: emin = '0;
        1: emin = SUM_MAX;
        default: begin
          w    = {$urandom, $urandom};
          emin = SUM_W'(w & ((64'd1 << $urandom_range(0, 40)) - 1'b1));
        end
      endcase
      case ($urandom_range(0, 4))
        0: ratio = 0;
        1: ratio = 16'hffff;
        2: ratio = 655;
        default: ratio = $urandom_range(0, 65535);
      endcase
      load_regs(half, cut, mid, emin, ratio, $urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 6))
        send_frame($urandom_range(1, span), cut, $urandom_range(0, 6), $urandom_range(0, 15),
                   $urandom_range(0, 7) == 0);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d bins over %0d register settings, %0d frames judged",
             bins_sent, settings_loaded, frames_judged);
    $display("summary: verdict codes seen (bit per code, silent down to cutoff) %b, %0d mismatches",
             verdicts_seen, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
